// ----- rtl/olvr_pkg.sv -----
// Package for the ordered list with value removal.
// Holds the command and status codes, item structs and the cell control struct.
// No dependencies.
`timescale 1ns / 1ps

package olvr_pkg;

	localparam int unsigned VALUE_W = 32;
	localparam int unsigned CMD_W   = 2;
	localparam int unsigned STAT_W  = 2;
	localparam int unsigned COUNT_W = 5;

	typedef enum logic [CMD_W-1:0] {
		CMD_ADD_FRONT = 2'd0,
		CMD_ADD_BACK  = 2'd1,
		CMD_REMOVE    = 2'd2
	} cmd_t;

	typedef enum logic [STAT_W-1:0] {
		ST_DONE      = 2'd0,
		ST_FULL      = 2'd1,
		ST_NOT_FOUND = 2'd2
	} status_t;

	typedef struct packed {
		logic [CMD_W-1:0]          command;
		logic signed [VALUE_W-1:0] value;
	} req_item_t;

	typedef struct packed {
		status_t                   status;
		logic [COUNT_W-1:0]        count;
		logic                      is_empty;
		logic signed [VALUE_W-1:0] front_value;
		logic signed [VALUE_W-1:0] back_value;
	} rsp_item_t;

	// Per-cycle operation broadcast to every cell
	typedef struct packed {
		logic shift_in;   // add at front: every cell takes its left neighbor
		logic append;     // add at back: first free cell takes the value
		logic remove;     // remove: cells at or after the match take the right neighbor
	} cell_ctl_t;

endpackage

// ----- rtl/olvr_cell.sv -----
// One storage cell of the ordered list: an entry and its occupied flag.
// Depends on olvr_pkg for the value width and the cell control struct.
`timescale 1ns / 1ps

module olvr_cell
	import olvr_pkg::*;
(
	input  logic                      clk,
	input  logic                      arst_n,
	input  cell_ctl_t                 ctl,
	input  logic signed [VALUE_W-1:0] value,
	input  logic signed [VALUE_W-1:0] left_data,
	input  logic                      left_valid,
	input  logic signed [VALUE_W-1:0] right_data,
	input  logic                      right_valid,
	input  logic                      hit_in,
	output logic                      hit_out,
	output logic signed [VALUE_W-1:0] data,
	output logic                      valid,
	output logic signed [VALUE_W-1:0] data_next,
	output logic                      valid_next
);

	logic signed [VALUE_W-1:0] data_q;
	logic                      valid_q;
	logic                      take_right;

	// Pass on whether a match has been seen at or before this cell
	assign hit_out    = hit_in | (valid_q && (data_q == value));
	assign take_right = ctl.remove && hit_out;

	// Choose the next contents from the broadcast operation
	always_comb begin
		data_next  = data_q;
		valid_next = valid_q;
		if (ctl.shift_in) begin
			data_next  = left_data;
			valid_next = left_valid;
		end else if (ctl.append) begin
			if (!valid_q && left_valid) begin
				data_next  = value;
				valid_next = 1'b1;
			end
		end else if (take_right) begin
			data_next  = right_data;
			valid_next = right_valid;
		end
	end

	// Hold the occupied flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= valid_next;
		end
	end

	// Hold the entry
	always_ff @(posedge clk) begin
		data_q <= data_next;
	end

	assign data  = data_q;
	assign valid = valid_q;

endmodule

// ----- rtl/ordered_list_with_value_removal.sv -----
// Top level of the ordered list with value removal: a row of cells and a result register.
// Depends on olvr_pkg and olvr_cell.
//
//   channel | valid     | stall     | payload
//   request | req_valid | req_stall | req_item (command, value)
//   result  | rsp_valid | rsp_stall | rsp_item (status, count, is_empty, front, back)
//
// All cells compare and shift together, and the result register loads at the edge
// where the item is accepted. An item may follow every cycle while req_stall is low.
// The longest path is the match ripple along the row of cells into the back-value select.
// Reset clears the occupied flags, the count and the result valid; entries need no reset.
// req_stall is high only while a result waits in the register and rsp_stall is high.
`timescale 1ns / 1ps

module ordered_list_with_value_removal
	import olvr_pkg::*;
#(
	parameter int unsigned CAPACITY = 16
)(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      req_valid,
	output logic      req_stall,
	input  req_item_t req_item,
	output logic      rsp_valid,
	input  logic      rsp_stall,
	output rsp_item_t rsp_item
);

	localparam int unsigned CW = $clog2(CAPACITY + 1);

	logic signed [VALUE_W-1:0] cell_data [CAPACITY];
	logic                      cell_valid [CAPACITY];
	logic signed [VALUE_W-1:0] cell_dn [CAPACITY];
	logic                      cell_vn [CAPACITY];
	logic [CAPACITY:0]         hit;

	logic [CW-1:0]    count_q;
	logic [CW-1:0]    count_next;
	logic [CW+4:0]    count_ext;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;
	logic             accept;
	logic             full;
	logic             found;
	logic             is_add;
	cell_ctl_t        ctl;
	status_t          status;
	logic signed [VALUE_W-1:0] back_next;

	assign accept = req_valid && !req_stall;
	assign full   = cell_valid[CAPACITY-1];
	assign found  = hit[CAPACITY];
	assign is_add = (req_item.command == CMD_ADD_FRONT) || (req_item.command == CMD_ADD_BACK);

	// Decode the operation and its status
	always_comb begin
		ctl    = '0;
		status = ST_DONE;
		case (req_item.command)
			CMD_ADD_FRONT: begin
				if (full) status = ST_FULL;
				else      ctl.shift_in = accept;
			end
			CMD_ADD_BACK: begin
				if (full) status = ST_FULL;
				else      ctl.append = accept;
			end
			CMD_REMOVE: begin
				if (!found) status = ST_NOT_FOUND;
				else        ctl.remove = accept;
			end
			default: begin
				status = ST_DONE;
			end
		endcase
	end

	assign hit[0] = 1'b0;

	// Build the row of cells
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [VALUE_W-1:0] left_d;
		logic                      left_v;
		logic signed [VALUE_W-1:0] right_d;
		logic                      right_v;

		if (i == 0) begin : g_first
			assign left_d = req_item.value;
			assign left_v = 1'b1;
		end else begin : g_mid
			assign left_d = cell_data[i-1];
			assign left_v = cell_valid[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[i];
			assign right_v = 1'b0;
		end else begin : g_inner
			assign right_d = cell_data[i+1];
			assign right_v = cell_valid[i+1];
		end

		olvr_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctl         (ctl),
			.value       (req_item.value),
			.left_data   (left_d),
			.left_valid  (left_v),
			.right_data  (right_d),
			.right_valid (right_v),
			.hit_in      (hit[i]),
			.hit_out     (hit[i+1]),
			.data        (cell_data[i]),
			.valid       (cell_valid[i]),
			.data_next   (cell_dn[i]),
			.valid_next  (cell_vn[i])
		);
	end

	// Advance the count
	always_comb begin
		count_next = count_q;
		if (ctl.shift_in || ctl.append) begin
			count_next = count_q + CW'(1);
		end else if (ctl.remove) begin
			count_next = count_q - CW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			count_q <= count_next;
		end
	end

	// Pick the last occupied cell of the next state
	always_comb begin
		back_next = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (cell_vn[i] && ((i == CAPACITY - 1) || !cell_vn[(i + 1) % CAPACITY])) begin
				back_next = back_next | cell_dn[i];
			end
		end
	end

	assign count_ext = {5'd0, count_next};

	// Load the result register
	always_ff @(posedge clk) begin
		if (accept) begin
			rsp_q.status      <= status;
			rsp_q.count       <= count_ext[COUNT_W-1:0];
			rsp_q.is_empty    <= !cell_vn[0];
			rsp_q.front_value <= cell_vn[0] ? cell_dn[0] : '0;
			rsp_q.back_value  <= back_next;
		end
	end

	// Hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (accept) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign req_stall = rsp_valid_q && rsp_stall;
	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_q;

	// Occupancy and count agree at both ends of the row
	a_empty_count: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) == !cell_valid[0])
		else $error("count and front occupancy disagree");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		full == (count_q == CW'(CAPACITY)))
		else $error("count and back occupancy disagree");

	// An add that arrives while full is refused and leaves the count alone
	a_full_refused: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_add && full) |=> (rsp_q.status == ST_FULL) && $stable(count_q))
		else $error("add while full was not refused");

	// An empty result reports zero front and back values
	a_empty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid_q && rsp_q.is_empty) |-> (rsp_q.front_value == '0) && (rsp_q.back_value == '0))
		else $error("empty result carries nonzero values");

endmodule

// ----- sim/ordered_list_with_value_removal_test.sv -----
// Self-checking testbench for the ordered list with value removal.
// Drives directed and random items through the valid/stall channels and checks each result.
// Depends on olvr_pkg and ordered_list_with_value_removal.
`timescale 1ns / 1ps

module ordered_list_with_value_removal_test;
	import olvr_pkg::*;

	localparam int unsigned LIST_DEPTH = 16;
	localparam int unsigned RANDOM_ITEMS = 475;
	localparam int unsigned CYCLE_LIMIT = 40000;
	localparam int unsigned LONG_HOLD = 40;
	localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
	localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      req_valid = 1'b0;
	logic      req_stall;
	req_item_t req_item = '0;
	logic      rsp_valid;
	logic      rsp_stall = 1'b0;
	rsp_item_t rsp_item;

	// Stimulus, predicted list contents and pending results
	req_item_t                 item_q[$];
	logic signed [VALUE_W-1:0] list_vals[$];
	rsp_item_t                 expected_q[$];

	logic req_taken = 1'b0;
	logic rsp_taken = 1'b0;
	int   req_gap = 0;
	int   rsp_gap = 0;
	int   hold_left = 0;
	int   results_seen = 0;
	bit   req_idle_on = 1'b1;
	bit   rsp_idle_on = 1'b1;
	int   fail_count = 0;
	int   cycle_count = 0;

	// Coverage tallies for the summary
	int cmd_hits[4] = '{0, 0, 0, 0};
	int full_refusals = 0;
	int misses = 0;
	int drained = 0;
	int filled = 0;

	ordered_list_with_value_removal #(
		.CAPACITY(LIST_DEPTH)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item(req_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item(rsp_item)
	);

	always #10 clk = ~clk;

	function automatic req_item_t make_item(logic [CMD_W-1:0] cmd, logic signed [VALUE_W-1:0] v);
		req_item_t it;
		it.command = cmd;
		it.value = v;
		return it;
	endfunction

	// Apply one item to the list copy and return the result it should produce
	function automatic rsp_item_t apply_to_list(req_item_t it);
		rsp_item_t r;
		int hit;
		r.status = ST_DONE;
		hit = -1;
		case (it.command)
			CMD_ADD_FRONT: begin
				if (list_vals.size() >= LIST_DEPTH)
					r.status = ST_FULL;
				else
					list_vals.push_front(it.value);
			end
			CMD_ADD_BACK: begin
				if (list_vals.size() >= LIST_DEPTH)
					r.status = ST_FULL;
				else
					list_vals.push_back(it.value);
			end
			CMD_REMOVE: begin
				foreach (list_vals[i])
					if (hit < 0 && list_vals[i] == it.value)
						hit = i;
				if (hit < 0)
					r.status = ST_NOT_FOUND;
				else
					list_vals.delete(hit);
			end
			default: ;
		endcase
		r.count = COUNT_W'(list_vals.size());
		r.is_empty = (list_vals.size() == 0);
		r.front_value = r.is_empty ? '0 : list_vals[0];
		r.back_value = r.is_empty ? '0 : list_vals[list_vals.size() - 1];
		return r;
	endfunction

	// Predict on every accepted request item
	always @(posedge clk) begin : list_predictor
		rsp_item_t exp_rsp;
		req_taken <= arst_n && req_valid && !req_stall;
		if (arst_n && req_valid && !req_stall) begin
			exp_rsp = apply_to_list(req_item);
			expected_q.push_back(exp_rsp);
			cmd_hits[req_item.command]++;
			if (exp_rsp.status == ST_FULL)
				full_refusals++;
			if (exp_rsp.status == ST_NOT_FOUND)
				misses++;
			if (req_item.command == CMD_REMOVE && exp_rsp.status == ST_DONE && exp_rsp.is_empty)
				drained++;
			if (exp_rsp.status == ST_DONE && exp_rsp.count == LIST_DEPTH &&
				req_item.command != CMD_REMOVE && req_item.command != CMD_UNUSED)
				filled++;
		end
	end

	// Check every accepted result item against the oldest prediction
	always @(posedge clk) begin : result_monitor
		rsp_item_t exp_rsp;
		rsp_taken <= arst_n && rsp_valid && !rsp_stall;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_q.size() == 0) begin
				$error("result item with no prediction waiting");
				fail_count++;
			end else begin
				exp_rsp = expected_q.pop_front();
				if (rsp_item.status !== exp_rsp.status) begin
					$error("status: expected %0d, got %0d", exp_rsp.status, rsp_item.status);
					fail_count++;
				end
				if (rsp_item.count !== exp_rsp.count) begin
					$error("count: expected %0d, got %0d", exp_rsp.count, rsp_item.count);
					fail_count++;
				end
				if (rsp_item.is_empty !== exp_rsp.is_empty) begin
					$error("is_empty: expected %0d, got %0d", exp_rsp.is_empty, rsp_item.is_empty);
					fail_count++;
				end
				if (rsp_item.front_value !== exp_rsp.front_value) begin
					$error("front_value: expected %0d, got %0d",
						exp_rsp.front_value, rsp_item.front_value);
					fail_count++;
				end
				if (rsp_item.back_value !== exp_rsp.back_value) begin
					$error("back_value: expected %0d, got %0d",
						exp_rsp.back_value, rsp_item.back_value);
					fail_count++;
				end
			end
		end
	end

	// Offer request items; hold a stalled item, then wait out the drawn gap
	always @(negedge clk) begin : request_driver
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else if (!req_valid || req_taken) begin
			if (req_gap > 0) begin
				req_valid <= 1'b0;
				req_gap--;
			end else if (item_q.size() > 0) begin
				req_item <= item_q.pop_front();
				req_valid <= 1'b1;
				if ($urandom_range(0, 29) == 0)
					req_idle_on = !req_idle_on;
				req_gap = req_idle_on ? $urandom_range(0, 3) : 0;
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Stall result items at random, with two long hold-offs to back up the input
	always @(negedge clk) begin : result_receiver
		if (rsp_taken) begin
			results_seen++;
			if (results_seen == 150 || results_seen == 350)
				hold_left = LONG_HOLD;
			if ($urandom_range(0, 29) == 0)
				rsp_idle_on = !rsp_idle_on;
			rsp_gap = rsp_idle_on ? $urandom_range(0, 3) : 0;
		end
		if (hold_left > 0) begin
			hold_left--;
			rsp_stall <= 1'b1;
		end else if (rsp_gap > 0) begin
			rsp_gap--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
		end
	end

	// End the run if it hangs
	always @(posedge clk) begin : watchdog
		cycle_count++;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Build the stimulus, reset, then wait for the list to drain
	initial begin : stimulus
		logic signed [VALUE_W-1:0] value_pool[8];
		logic signed [VALUE_W-1:0] v;
		logic [CMD_W-1:0]          cmd;
		int                        phase_left;
		bit                        grow;
		int                        pick;

		// Remove and unused code on the empty list
		item_q.push_back(make_item(CMD_REMOVE, 32'sd5));
		item_q.push_back(make_item(CMD_UNUSED, -32'sd1));

		// Fill to capacity from both ends, with extremes and repeated values
		for (int i = 0; i < LIST_DEPTH; i++) begin
			case (i)
				0: v = VAL_MAX;
				1: v = VAL_MIN;
				2: v = '0;
				3: v = -32'sd1;
				default: v = (i % 3 == 0) ? 32'sd7 : $signed($urandom);
			endcase
			item_q.push_back(make_item(i[0] ? CMD_ADD_FRONT : CMD_ADD_BACK, v));
		end

		// Adds while full, a miss, unused code, then removals of repeated and extreme values
		item_q.push_back(make_item(CMD_ADD_FRONT, 32'sd1));
		item_q.push_back(make_item(CMD_ADD_BACK, 32'sd2));
		item_q.push_back(make_item(CMD_REMOVE, 32'sd12345));
		item_q.push_back(make_item(CMD_UNUSED, VAL_MAX));
		item_q.push_back(make_item(CMD_REMOVE, 32'sd7));
		item_q.push_back(make_item(CMD_REMOVE, VAL_MIN));
		item_q.push_back(make_item(CMD_REMOVE, VAL_MAX));

		// Random part: alternate growing and shrinking phases over a small value pool
		foreach (value_pool[i])
			value_pool[i] = $signed($urandom);
		phase_left = 0;
		grow = 1'b1;
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (phase_left == 0) begin
				phase_left = $urandom_range(20, 50);
				grow = !grow;
				value_pool[$urandom_range(0, 7)] = $signed($urandom);
			end
			phase_left--;
			pick = $urandom_range(0, 99);
			if (pick < (grow ? 35 : 15))
				cmd = CMD_ADD_FRONT;
			else if (pick < (grow ? 70 : 30))
				cmd = CMD_ADD_BACK;
			else if (pick < 95)
				cmd = CMD_REMOVE;
			else
				cmd = CMD_UNUSED;
			if ($urandom_range(0, 99) < 82)
				v = value_pool[$urandom_range(0, 7)];
			else
				v = $signed($urandom);
			item_q.push_back(make_item(cmd, v));
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (item_q.size() != 0 || req_valid || expected_q.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("Run covered %0d items: %0d add-front, %0d add-back, %0d remove, %0d unused code.",
			cmd_hits[0] + cmd_hits[1] + cmd_hits[2] + cmd_hits[3],
			cmd_hits[0], cmd_hits[1], cmd_hits[2], cmd_hits[3]);
		$display("Saw %0d full refusals and %0d misses; list drained %0d times, filled %0d times.",
			full_refusals, misses, drained, filled);
		if (fail_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/olvr_pkg.sv
rtl/olvr_cell.sv
rtl/ordered_list_with_value_removal.sv
sim/ordered_list_with_value_removal_test.sv
